// ===== rtl/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants and types of the pixel frame deframer and checker.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int ROWS_DEFAULT          = 48;
    localparam int WORDS_PER_ROW_DEFAULT = 10;

    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_PATTERN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_TYPE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_HEADER_ID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_FOOTER_ID  = 3'd4;

    localparam logic [31:0] HEADER_PATTERN_RST = 32'hAAAA_AAAA;
    localparam logic [31:0] FOOTER_PATTERN_RST = 32'hF0F0_F0F0;
    localparam logic [1:0]  EXP_TYPE_RST       = 2'd2;
    localparam logic [3:0]  ROW_HEADER_ID_RST  = 4'd15;
    localparam logic [3:0]  ROW_FOOTER_ID_RST  = 4'd14;

    localparam logic [6:0] TAG_ROW = 7'd7;

    localparam logic [1:0] KIND_PAIR  = 2'd0;
    localparam logic [1:0] KIND_ROW   = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  row;
        logic [2:0]  pair;
        logic [15:0] sample_even;
        logic [15:0] sample_odd;
        logic        row_error;
        logic        header_skipped;
        logic        data_error;
        logic        footer_error;
        logic        frame_error;
        logic [1:0]  tag_type;
        logic [15:0] tag_count;
    } pfd_result_t;

endpackage

// ===== rtl/pixel_frame_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// pixel_frame_deframer_checker
// Deframes a readout word stream: header search, row parsing into sample
// pairs, per-row id/type/row/counter checks and a frame status item.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   word
//   out      output     out_valid / out_stall kind .. tag_count
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// one word per cycle unless in_stall is high; results are registered
// counter history lives in a RAM; a flop per row marks it written,
// so reset needs no clearing pass
// in_stall rises only when the result register and skid stage are both full
// ----------------------------------------------------------------------------
module pixel_frame_deframer_checker #(
    parameter int ROWS          = pfd_pkg::ROWS_DEFAULT,
    parameter int WORDS_PER_ROW = pfd_pkg::WORDS_PER_ROW_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfd_pkg::WORD_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic [5:0]                    row,
    output logic [2:0]                    pair,
    output logic [15:0]                   sample_even,
    output logic [15:0]                   sample_odd,
    output logic                          row_error,
    output logic                          header_skipped,
    output logic                          data_error,
    output logic                          footer_error,
    output logic                          frame_error,
    output logic [1:0]                    tag_type,
    output logic [15:0]                   tag_count
);

    import pfd_pkg::*;

    logic        accept;
    logic        res_valid;
    pfd_result_t res;
    pfd_result_t out_data;
    logic        buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid & ~buf_full;

    pfd_parser #(
        .ROWS          (ROWS),
        .WORDS_PER_ROW (WORDS_PER_ROW)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    pfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign row            = out_data.row;
    assign pair           = out_data.pair;
    assign sample_even    = out_data.sample_even;
    assign sample_odd     = out_data.sample_odd;
    assign row_error      = out_data.row_error;
    assign header_skipped = out_data.header_skipped;
    assign data_error     = out_data.data_error;
    assign footer_error   = out_data.footer_error;
    assign frame_error    = out_data.frame_error;
    assign tag_type       = out_data.tag_type;
    assign tag_count      = out_data.tag_count;

    a_stall_needs_full_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled while result register empty");

    a_frame_error_is_or: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_FRAME) |->
            (frame_error == (header_skipped | data_error | footer_error)))
    else $error("frame error does not match its flags");

    a_no_frame_flags_on_rows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_FRAME) |-> !frame_error && !footer_error)
    else $error("frame flags on a row item");

    a_pair_has_no_row_error: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_PAIR) |-> !row_error)
    else $error("row error on a sample pair item");

endmodule

// ===== rtl/pfd_ram.sv =====
// ----------------------------------------------------------------------------
// pfd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pfd_parser.sv =====
// ----------------------------------------------------------------------------
// pfd_parser
// Frame parser: configuration registers, header search, row tracking,
// row checks against the per-row counter history, and result forming.
// ----------------------------------------------------------------------------
module pfd_parser #(
    parameter int ROWS          = pfd_pkg::ROWS_DEFAULT,
    parameter int WORDS_PER_ROW = pfd_pkg::WORDS_PER_ROW_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pfd_pkg::WORD_W-1:0]            cfg_data,
    input  logic                                  accept,
    input  logic [pfd_pkg::WORD_W-1:0]            word,
    output logic                                  res_valid,
    output pfd_pkg::pfd_result_t                  res
);

    import pfd_pkg::*;

    localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WIW = $clog2(WORDS_PER_ROW);
    localparam logic [RIW-1:0] ROW_LAST  = RIW'(ROWS - 1);
    localparam logic [WIW-1:0] WORD_LAST = WIW'(WORDS_PER_ROW - 1);

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_ROWS   = 2'd1,
        PH_FOOTER = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [RIW-1:0]   row_index_reg, row_index_next;
    logic [WIW-1:0]   word_index_reg, word_index_next;
    logic [31:0]      row_hdr_reg, row_hdr_next;
    logic             skip_reg, skip_next;
    logic             row_err_reg, row_err_next;
    logic [1:0]       tag_type_reg, tag_type_next;
    logic [15:0]      tag_cnt_reg, tag_cnt_next;
    logic [ROWS-1:0]  hist_valid_reg, hist_valid_next;
    logic             prev_valid_reg, prev_valid_next;

    logic [31:0]      header_pattern_reg;
    logic [31:0]      footer_pattern_reg;
    logic [1:0]       exp_type_reg;
    logic [3:0]       row_header_id_reg;
    logic [3:0]       row_footer_id_reg;

    logic             mem_re;
    logic             mem_we;
    logic [CNT_W-1:0] mem_rdata;
    logic [CNT_W-1:0] prev_cnt;
    logic             check_err;
    logic [3:0]       pair_wide;

    pfd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ROWS)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (row_index_reg),
        .wdata (row_hdr_reg[19:0]),
        .re    (mem_re),
        .raddr (row_index_reg),
        .rdata (mem_rdata)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pattern_reg <= HEADER_PATTERN_RST;
            footer_pattern_reg <= FOOTER_PATTERN_RST;
            exp_type_reg       <= EXP_TYPE_RST;
            row_header_id_reg  <= ROW_HEADER_ID_RST;
            row_footer_id_reg  <= ROW_FOOTER_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_PATTERN: header_pattern_reg <= cfg_data;
                CFG_FOOTER_PATTERN: footer_pattern_reg <= cfg_data;
                CFG_EXP_TYPE:       exp_type_reg       <= cfg_data[1:0];
                CFG_ROW_HEADER_ID:  row_header_id_reg  <= cfg_data[3:0];
                CFG_ROW_FOOTER_ID:  row_footer_id_reg  <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    assign prev_cnt  = prev_valid_reg ? mem_rdata : '0;
    assign pair_wide = 4'(word_index_reg) - 4'd1;

    // row checks, applied at the row footer
    always_comb
    begin
        check_err = 1'b0;
        if (row_hdr_reg[31:28] != row_header_id_reg)
        begin
            check_err = 1'b1;
        end
        if (word[23:20] != row_footer_id_reg)
        begin
            check_err = 1'b1;
        end
        if (row_hdr_reg[27:26] != exp_type_reg)
        begin
            check_err = 1'b1;
        end
        if (row_hdr_reg[25:20] != 6'(row_index_reg))
        begin
            check_err = 1'b1;
        end
        if (4'(row_hdr_reg[19:16] - prev_cnt[19:16]) != 4'd1)
        begin
            check_err = 1'b1;
        end
        if (16'(row_hdr_reg[15:0] - prev_cnt[15:0]) != 16'd1)
        begin
            check_err = 1'b1;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        row_index_next  = row_index_reg;
        word_index_next = word_index_reg;
        row_hdr_next    = row_hdr_reg;
        skip_next       = skip_reg;
        row_err_next    = row_err_reg;
        tag_type_next   = tag_type_reg;
        tag_cnt_next    = tag_cnt_reg;
        hist_valid_next = hist_valid_reg;
        prev_valid_next = prev_valid_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        res_valid       = 1'b0;
        res             = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_ROWS:
                begin
                    if (word_index_reg == '0)
                    begin
                        // row header: fetch this row's counter history
                        row_hdr_next    = word;
                        mem_re          = 1'b1;
                        prev_valid_next = hist_valid_reg[row_index_reg];
                        if (7'(row_index_reg) == TAG_ROW)
                        begin
                            tag_type_next = word[27:26];
                            tag_cnt_next  = word[15:0];
                        end
                        word_index_next = WIW'(1);
                    end
                    else if (word_index_reg == WORD_LAST)
                    begin
                        mem_we                          = 1'b1;
                        hist_valid_next[row_index_reg]  = 1'b1;
                        if (check_err)
                        begin
                            row_err_next = 1'b1;
                        end
                        res_valid       = 1'b1;
                        res.kind        = KIND_ROW;
                        res.row         = 6'(row_index_reg);
                        res.row_error   = check_err;
                        word_index_next = '0;
                        if (row_index_reg == ROW_LAST)
                        begin
                            row_index_next = '0;
                            phase_next     = PH_FOOTER;
                        end
                        else
                        begin
                            row_index_next = row_index_reg + RIW'(1);
                        end
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        res.kind        = KIND_PAIR;
                        res.row         = 6'(row_index_reg);
                        res.pair        = pair_wide[2:0];
                        res.sample_even = word[15:0];
                        res.sample_odd  = word[31:16];
                        word_index_next = word_index_reg + WIW'(1);
                    end
                end
                PH_FOOTER:
                begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_FRAME;
                    res.header_skipped = skip_reg;
                    res.data_error     = row_err_reg;
                    res.footer_error   = (word != footer_pattern_reg);
                    res.frame_error    = skip_reg | row_err_reg |
                                         (word != footer_pattern_reg);
                    res.tag_type       = tag_type_reg;
                    res.tag_count      = tag_cnt_reg;
                    skip_next          = 1'b0;
                    row_err_next       = 1'b0;
                    phase_next         = PH_SEARCH;
                end
                default:
                begin
                    if (word == header_pattern_reg)
                    begin
                        phase_next      = PH_ROWS;
                        row_index_next  = '0;
                        word_index_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_SEARCH;
                        skip_next  = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEARCH;
            row_index_reg  <= '0;
            word_index_reg <= '0;
            row_hdr_reg    <= '0;
            skip_reg       <= 1'b0;
            row_err_reg    <= 1'b0;
            tag_type_reg   <= '0;
            tag_cnt_reg    <= '0;
            hist_valid_reg <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            row_index_reg  <= row_index_next;
            word_index_reg <= word_index_next;
            row_hdr_reg    <= row_hdr_next;
            skip_reg       <= skip_next;
            row_err_reg    <= row_err_next;
            tag_type_reg   <= tag_type_next;
            tag_cnt_reg    <= tag_cnt_next;
            hist_valid_reg <= hist_valid_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

endmodule

// ===== rtl/pfd_out_buf.sv =====
// ----------------------------------------------------------------------------
// pfd_out_buf
// Result register with a skid stage; input stall comes from the skid state.
// ----------------------------------------------------------------------------
module pfd_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pfd_pkg::pfd_result_t push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pfd_pkg::pfd_result_t out_data
);

    import pfd_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    pfd_result_t main_reg;
    pfd_result_t skid_reg;
    logic        pop;

    assign pop       = main_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule
